// File: design/source_byte_tokenizer_unit_defines.svh
// Assertion macros for the source byte tokenizer unit.
// Used by the top level only; no other dependencies.
`ifndef SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sbt_pkg.sv
// Shared types, codes, keyword table and scan step function of the tokenizer.
// No dependencies; imported by all tokenizer modules.
package sbt_pkg;

	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;
	localparam int LEN_BITS    = 16;
	localparam int KW_BYTES    = 12;
	localparam int KW_IDX_BITS = $clog2(KW_BYTES);
	localparam int KW_LEN_BITS = $clog2(KW_BYTES + 1);
	localparam int NKW         = 36;
	localparam int MAX_RES     = 4;
	localparam int ITERS       = 4;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
	localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;

	// token kinds
	localparam logic [6:0] K_EOF = 7'd0;
	localparam logic [6:0] K_STR = 7'd1;
	localparam logic [6:0] K_INT = 7'd2;
	localparam logic [6:0] K_FLT = 7'd3;
	localparam logic [6:0] K_ID  = 7'd4;
	localparam logic [6:0] K_BAD = 7'd5;
	localparam logic [6:0] K_KW0 = 7'd6;
	localparam logic [6:0] OP_INC    = 7'd42;
	localparam logic [6:0] OP_PLUS   = 7'd43;
	localparam logic [6:0] OP_ARROW  = 7'd44;
	localparam logic [6:0] OP_DEC    = 7'd45;
	localparam logic [6:0] OP_MINUS  = 7'd46;
	localparam logic [6:0] OP_STAR   = 7'd47;
	localparam logic [6:0] OP_SLASH  = 7'd48;
	localparam logic [6:0] OP_PCT    = 7'd49;
	localparam logic [6:0] OP_EQEQ   = 7'd50;
	localparam logic [6:0] OP_ASSIGN = 7'd51;
	localparam logic [6:0] OP_NE     = 7'd52;
	localparam logic [6:0] OP_NOT    = 7'd53;
	localparam logic [6:0] OP_SHL    = 7'd54;
	localparam logic [6:0] OP_LE     = 7'd55;
	localparam logic [6:0] OP_LT     = 7'd56;
	localparam logic [6:0] OP_SHR    = 7'd57;
	localparam logic [6:0] OP_GE     = 7'd58;
	localparam logic [6:0] OP_GT     = 7'd59;
	localparam logic [6:0] OP_LAND   = 7'd60;
	localparam logic [6:0] OP_AND    = 7'd61;
	localparam logic [6:0] OP_LOR    = 7'd62;
	localparam logic [6:0] OP_OR     = 7'd63;
	localparam logic [6:0] OP_XOR    = 7'd64;
	localparam logic [6:0] OP_TILDE  = 7'd65;
	localparam logic [6:0] OP_LPAR   = 7'd66;
	localparam logic [6:0] OP_RPAR   = 7'd67;
	localparam logic [6:0] OP_LBRACE = 7'd68;
	localparam logic [6:0] OP_RBRACE = 7'd69;
	localparam logic [6:0] OP_LBRK   = 7'd70;
	localparam logic [6:0] OP_RBRK   = 7'd71;
	localparam logic [6:0] OP_SEMI   = 7'd72;
	localparam logic [6:0] OP_COMMA  = 7'd73;
	localparam logic [6:0] OP_DOT    = 7'd74;
	localparam logic [6:0] OP_COLON  = 7'd75;
	localparam logic [6:0] OP_QUEST  = 7'd76;

	// error codes
	localparam logic [2:0] E_NONE   = 3'd0;
	localparam logic [2:0] E_UNTERM = 3'd1;
	localparam logic [2:0] E_HEX    = 3'd2;
	localparam logic [2:0] E_BIN    = 3'd3;
	localparam logic [2:0] E_OCT    = 3'd4;
	localparam logic [2:0] E_CHAR   = 3'd5;

	// suffix codes
	localparam logic [2:0] S_NONE = 3'd0;
	localparam logic [2:0] S_F    = 3'd1;
	localparam logic [2:0] S_L    = 3'd2;
	localparam logic [2:0] S_LL   = 3'd3;
	localparam logic [2:0] S_U    = 3'd4;
	localparam logic [2:0] S_UL   = 3'd5;
	localparam logic [2:0] S_ULL  = 3'd6;

	// suffix flags: bit0 U seen, bits 2:1 count of L
	localparam logic [2:0] SF_ULL = 3'd5;
	localparam logic [1:0] L_TWO  = 2'd2;
	localparam logic [1:0] L_ONE  = 2'd1;

	// bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UL    = 8'h4c;
	localparam logic [7:0] CH_UO    = 8'h4f;
	localparam logic [7:0] CH_UU    = 8'h55;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_USCR  = 8'h5f;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF_   = 8'h66;
	localparam logic [7:0] CH_LL    = 8'h6c;
	localparam logic [7:0] CH_LO    = 8'h6f;
	localparam logic [7:0] CH_LU    = 8'h75;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_PIPE  = 8'h7c;
	localparam logic [7:0] CH_RBRC  = 8'h7d;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_HIGH  = 8'h80;

	// keyword bytes, first byte in the top bits
	localparam logic [KW_BYTES*8-1:0] KW_TAB [NKW] = '{
		96'he5a682e69e9c_000000000000, 96'he590a6e58899_000000000000,
		96'he587bde695b0_000000000000, 96'he8bf94e59b9e_000000000000,
		96'he58f98e9878f_000000000000, 96'he695b4e695b0_000000000000,
		96'he5b08fe695b0_000000000000, 96'he5ad97e7aca6e4b8b2_000000,
		96'he5b883e5b094_000000000000, 96'he7bb93e69e84e4bd93_000000,
		96'he69e9ae4b8be_000000000000, 96'he5bd93_000000000000000000,
		96'he5beaae78eaf_000000000000, 96'he4b8ade696ad_000000000000,
		96'he7bba7e7bbad_000000000000, 96'he98089e68ba9_000000000000,
		96'he68385e586b5_000000000000, 96'he9bb98e8aea4_000000000000,
		96'he79c9f_000000000000000000, 96'he58187_000000000000000000,
		96'he7a9ba_000000000000000000, 96'he697a0_000000000000000000,
		96'he6a8a1e59d97_000000000000, 96'he5afbce585a5_000000000000,
		96'he591bde5908de7a9bae997b4,  96'he68ea5e58fa3_000000000000,
		96'he7b1bb_000000000000000000, 96'he6a8a1e69dbf_000000000000,
		96'he5b8b8e9878f_000000000000, 96'he99d99e68081_000000000000,
		96'he585ace5bc80_000000000000, 96'he7a781e69c89_000000000000,
		96'he4bf9de68aa4_000000000000, 96'he8999ae68b9f_000000000000,
		96'he9878de58699_000000000000, 96'he68abde8b1a1_000000000000
	};
	localparam logic [KW_LEN_BITS-1:0] KW_LEN [NKW] = '{
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd9, 4'd6, 4'd9,
		4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd3, 4'd3,
		4'd3, 4'd3, 4'd6, 4'd6, 4'd12, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6
	};

	typedef enum logic [30:0] {
		M_IDLE    = 31'd1 << 0,
		M_SLASH   = 31'd1 << 1,
		M_COMMENT = 31'd1 << 2,
		M_STR     = 31'd1 << 3,
		M_ESC     = 31'd1 << 4,
		M_ZERO    = 31'd1 << 5,
		M_DEC     = 31'd1 << 6,
		M_DECDOT  = 31'd1 << 7,
		M_FRAC    = 31'd1 << 8,
		M_EEI     = 31'd1 << 9,
		M_ESI     = 31'd1 << 10,
		M_EEF     = 31'd1 << 11,
		M_ESF     = 31'd1 << 12,
		M_EDIG    = 31'd1 << 13,
		M_SUFI    = 31'd1 << 14,
		M_SUFF    = 31'd1 << 15,
		M_HEX0    = 31'd1 << 16,
		M_HEX     = 31'd1 << 17,
		M_BIN0    = 31'd1 << 18,
		M_BIN     = 31'd1 << 19,
		M_OCT0    = 31'd1 << 20,
		M_OCT     = 31'd1 << 21,
		M_IDENT   = 31'd1 << 22,
		M_PLUS    = 31'd1 << 23,
		M_MINUS   = 31'd1 << 24,
		M_EQ      = 31'd1 << 25,
		M_BANG    = 31'd1 << 26,
		M_LT      = 31'd1 << 27,
		M_GT      = 31'd1 << 28,
		M_AMP     = 31'd1 << 29,
		M_PIPE    = 31'd1 << 30
	} mode_t;

	typedef logic [KW_BYTES-1:0][7:0] kwbuf_t;

	typedef struct packed {
		mode_t                  mode;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LINE_BITS-1:0]   tsl;
		logic [COLUMN_BITS-1:0] tsc;
		logic [LEN_BITS-1:0]    cnt;
		logic [2:0]             suf;
	} st_t;

	typedef struct packed {
		logic [6:0]             kind;
		logic [2:0]             err;
		logic [2:0]             suf;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LEN_BITS-1:0]    len;
	} tok_t;

	typedef struct packed {
		logic [2:0]                cnt;
		logic                      last;
		tok_t [MAX_RES-1:0]        tok;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		st_t                    st;
		logic                   done;
		logic                   ended;
		logic [1:0]             n;
		tok_t [1:0]             tok;
		logic                   kw_we;
		logic [KW_IDX_BITS-1:0] kw_idx;
		logic [7:0]             kw_d;
	} it_t;

	function automatic st_t start_state();
		st_t s;
		s.mode = M_IDLE;
		s.line = LINE_BITS'(1);
		s.col  = COLUMN_BITS'(1);
		s.tsl  = LINE_BITS'(1);
		s.tsc  = COLUMN_BITS'(1);
		s.cnt  = '0;
		s.suf  = '0;
		return s;
	endfunction

	function automatic logic is_dig(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic is_xdig(logic [7:0] c);
		return is_dig(c) || (c >= CH_LA && c <= CH_LF_) || (c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic id_start(logic [7:0] c);
		return c == CH_USCR || is_alpha(c) || c >= CH_HIGH;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic st_t adv(st_t s, logic [7:0] c);
		st_t r;
		r = s;
		if (c == CH_LF) begin
			if (s.line != LINE_MAX) r.line = s.line + 1'b1;
			r.col = COLUMN_BITS'(1);
		end else if (s.col != COL_MAX) begin
			r.col = s.col + 1'b1;
		end
		return r;
	endfunction

	function automatic st_t take(st_t s, logic [7:0] c);
		st_t r;
		r = adv(s, c);
		if (s.cnt != LEN_MAX) r.cnt = s.cnt + 1'b1;
		return r;
	endfunction

	function automatic tok_t mk_tok(logic [6:0] kind, logic [2:0] err, logic [2:0] suf,
			logic [LINE_BITS-1:0] line, logic [COLUMN_BITS-1:0] col,
			logic [LEN_BITS-1:0] len);
		tok_t t;
		t.kind = kind;
		t.err  = err;
		t.suf  = suf;
		t.line = line;
		t.col  = col;
		t.len  = len;
		return t;
	endfunction

	function automatic tok_t tok_of(st_t s, logic [6:0] kind, logic [2:0] err, logic [2:0] suf);
		return mk_tok(kind, err, suf, s.tsl, s.tsc, s.cnt);
	endfunction

	function automatic it_t push(it_t r, tok_t t);
		it_t o;
		o = r;
		o.tok[r.n[0]] = t;
		o.n = r.n + 2'd1;
		return o;
	endfunction

	function automatic logic [2:0] suffix_code(logic [2:0] f);
		logic [2:0] code;
		if (f[0]) code = (f[2:1] == L_TWO) ? S_ULL : ((f[2:1] == L_ONE) ? S_UL : S_U);
		else code = (f[2:1] == L_TWO) ? S_LL : ((f[2:1] == L_ONE) ? S_L : S_NONE);
		return code;
	endfunction

	// {valid, kind}
	function automatic logic [7:0] single_op(logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_STAR:  r = {1'b1, OP_STAR};
			CH_PCT:   r = {1'b1, OP_PCT};
			CH_CARET: r = {1'b1, OP_XOR};
			CH_TILDE: r = {1'b1, OP_TILDE};
			CH_LPAR:  r = {1'b1, OP_LPAR};
			CH_RPAR:  r = {1'b1, OP_RPAR};
			CH_LBRC:  r = {1'b1, OP_LBRACE};
			CH_RBRC:  r = {1'b1, OP_RBRACE};
			CH_LBRK:  r = {1'b1, OP_LBRK};
			CH_RBRK:  r = {1'b1, OP_RBRK};
			CH_SEMI:  r = {1'b1, OP_SEMI};
			CH_COMMA: r = {1'b1, OP_COMMA};
			CH_DOT:   r = {1'b1, OP_DOT};
			CH_COLON: r = {1'b1, OP_COLON};
			CH_QUEST: r = {1'b1, OP_QUEST};
			default:  r = '0;
		endcase
		return r;
	endfunction

	function automatic logic pair_start(logic [7:0] c, output mode_t m);
		logic v;
		v = 1'b1;
		m = M_IDLE;
		case (c)
			CH_PLUS:  m = M_PLUS;
			CH_MINUS: m = M_MINUS;
			CH_EQ:    m = M_EQ;
			CH_BANG:  m = M_BANG;
			CH_LT:    m = M_LT;
			CH_GT:    m = M_GT;
			CH_AMP:   m = M_AMP;
			CH_PIPE:  m = M_PIPE;
			default:  v = 1'b0;
		endcase
		return v;
	endfunction

	// {two-byte kind or K_EOF when none, one-byte kind}
	function automatic logic [13:0] pair_kinds(mode_t m, logic [7:0] c);
		logic [6:0] k2;
		logic [6:0] k1;
		k2 = K_EOF;
		k1 = OP_OR;
		case (m)
			M_PLUS: begin
				k1 = OP_PLUS;
				if (c == CH_PLUS) k2 = OP_INC;
			end
			M_MINUS: begin
				k1 = OP_MINUS;
				if (c == CH_GT) k2 = OP_ARROW;
				else if (c == CH_MINUS) k2 = OP_DEC;
			end
			M_EQ: begin
				k1 = OP_ASSIGN;
				if (c == CH_EQ) k2 = OP_EQEQ;
			end
			M_BANG: begin
				k1 = OP_NOT;
				if (c == CH_EQ) k2 = OP_NE;
			end
			M_LT: begin
				k1 = OP_LT;
				if (c == CH_LT) k2 = OP_SHL;
				else if (c == CH_EQ) k2 = OP_LE;
			end
			M_GT: begin
				k1 = OP_GT;
				if (c == CH_GT) k2 = OP_SHR;
				else if (c == CH_EQ) k2 = OP_GE;
			end
			M_AMP: begin
				k1 = OP_AND;
				if (c == CH_AMP) k2 = OP_LAND;
			end
			default: begin
				k1 = OP_OR;
				if (c == CH_PIPE) k2 = OP_LOR;
			end
		endcase
		return {k2, k1};
	endfunction

	function automatic logic [6:0] ident_kind(logic [LEN_BITS-1:0] cnt, kwbuf_t kb);
		logic [6:0] k;
		logic       m;
		k = K_ID;
		if (cnt <= LEN_BITS'(KW_BYTES)) begin
			for (int i = 0; i < NKW; i++) begin
				m = (LEN_BITS'(KW_LEN[i]) == cnt);
				for (int j = 0; j < KW_BYTES; j++) begin
					if (KW_LEN_BITS'(j) < KW_LEN[i] &&
							kb[j] != KW_TAB[i][8*(KW_BYTES-1-j) +: 8])
						m = 1'b0;
				end
				if (m) k = K_KW0 + 7'(i);
			end
		end
		return k;
	endfunction

	// One pass of the scanner; done clear means the byte is not consumed yet.
	function automatic it_t scan_iter(st_t s, logic [7:0] c, kwbuf_t kb);
		it_t        r;
		st_t        ns;
		logic [7:0] so;
		mode_t      pm;
		logic       pv;
		logic [13:0] pk;
		logic [6:0] kind;
		r = '0;
		r.st = s;
		r.done = 1'b1;
		ns = s;
		case (s.mode)
			M_IDLE: begin
				if (c == CH_NUL) begin
					r = push(r, mk_tok(K_EOF, E_NONE, S_NONE, s.line, s.col, '0));
					r.ended = 1'b1;
				end else if (is_ws(c)) begin
					r.st = adv(s, c);
				end else begin
					ns.tsl = s.line;
					ns.tsc = s.col;
					ns.cnt = '0;
					ns.suf = '0;
					ns = take(ns, c);
					so = single_op(c);
					pv = pair_start(c, pm);
					if (id_start(c)) begin
						r.kw_we = 1'b1;
						r.kw_idx = '0;
						r.kw_d = c;
						ns.mode = M_IDENT;
					end else if (c == CH_SLASH) ns.mode = M_SLASH;
					else if (c == CH_QUOTE) ns.mode = M_STR;
					else if (c == CH_0) ns.mode = M_ZERO;
					else if (is_dig(c)) ns.mode = M_DEC;
					else if (pv) ns.mode = pm;
					else if (so[7]) r = push(r, tok_of(ns, so[6:0], E_NONE, S_NONE));
					else r = push(r, tok_of(ns, K_BAD, E_CHAR, S_NONE));
					r.st = ns;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					r.st = adv(s, c);
					r.st.mode = M_COMMENT;
				end else begin
					r = push(r, tok_of(s, OP_SLASH, E_NONE, S_NONE));
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end
			end
			M_COMMENT: begin
				if (c == CH_LF || c == CH_NUL) begin
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end else begin
					r.st = adv(s, c);
				end
			end
			M_STR, M_ESC: begin
				if (c == CH_NUL) begin
					r = push(r, tok_of(s, K_BAD, E_UNTERM, S_NONE));
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end else begin
					ns = take(s, c);
					if (s.mode == M_ESC) ns.mode = M_STR;
					else if (c == CH_QUOTE) begin
						r = push(r, tok_of(ns, K_STR, E_NONE, S_NONE));
						ns.mode = M_IDLE;
					end else if (c == CH_BSL) ns.mode = M_ESC;
					r.st = ns;
				end
			end
			M_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					r.st = take(s, c);
					r.st.mode = M_HEX0;
				end else if (c == CH_LB || c == CH_UB) begin
					r.st = take(s, c);
					r.st.mode = M_BIN0;
				end else if (c == CH_LO || c == CH_UO) begin
					r.st = take(s, c);
					r.st.mode = M_OCT0;
				end else begin
					r.st.mode = M_DEC;
					r.done = 1'b0;
				end
			end
			M_DEC: begin
				if (is_dig(c)) r.st = take(s, c);
				else if (c == CH_DOT) r.st.mode = M_DECDOT;
				else if (c == CH_LE || c == CH_UE) begin
					r.st = take(s, c);
					r.st.mode = M_EEI;
				end else begin
					r.st.mode = M_SUFI;
					r.done = 1'b0;
				end
			end
			M_DECDOT: begin
				if (is_dig(c)) begin
					r.st = take(take(s, CH_DOT), c);
					r.st.mode = M_FRAC;
				end else begin
					r = push(r, tok_of(s, K_INT, E_NONE, S_NONE));
					r = push(r, mk_tok(OP_DOT, E_NONE, S_NONE, s.line, s.col, LEN_BITS'(1)));
					r.st = adv(s, CH_DOT);
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end
			end
			M_FRAC: begin
				if (is_dig(c)) r.st = take(s, c);
				else if (c == CH_LE || c == CH_UE) begin
					r.st = take(s, c);
					r.st.mode = M_EEF;
				end else begin
					r.st.mode = M_SUFF;
					r.done = 1'b0;
				end
			end
			M_EEI, M_EEF, M_ESI, M_ESF: begin
				if (is_dig(c)) begin
					r.st = take(s, c);
					r.st.mode = M_EDIG;
				end else if ((s.mode == M_EEI || s.mode == M_EEF) &&
						(c == CH_PLUS || c == CH_MINUS)) begin
					r.st = take(s, c);
					r.st.mode = (s.mode == M_EEI) ? M_ESI : M_ESF;
				end else begin
					r.st.mode = (s.mode == M_EEI || s.mode == M_ESI) ? M_SUFI : M_SUFF;
					r.done = 1'b0;
				end
			end
			M_EDIG: begin
				if (is_dig(c)) r.st = take(s, c);
				else begin
					r.st.mode = M_SUFF;
					r.done = 1'b0;
				end
			end
			M_SUFI, M_SUFF: begin
				kind = (s.mode == M_SUFI) ? K_INT : K_FLT;
				if (s.suf == 3'd0 && (c == CH_LF_ || c == CH_UF)) begin
					ns = take(s, c);
					r = push(r, tok_of(ns, kind, E_NONE, S_F));
					ns.mode = M_IDLE;
					r.st = ns;
				end else if (((c == CH_LU || c == CH_UU) && !s.suf[0]) ||
						((c == CH_LL || c == CH_UL) && s.suf[2:1] < L_TWO)) begin
					ns = take(s, c);
					if (c == CH_LU || c == CH_UU) ns.suf[0] = 1'b1;
					else ns.suf = s.suf + 3'd2;
					if (ns.suf == SF_ULL) begin
						r = push(r, tok_of(ns, kind, E_NONE, S_ULL));
						ns.mode = M_IDLE;
					end
					r.st = ns;
				end else begin
					r = push(r, tok_of(s, kind, E_NONE, suffix_code(s.suf)));
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end
			end
			M_HEX0, M_HEX: begin
				if (is_xdig(c)) begin
					r.st = take(s, c);
					r.st.mode = M_HEX;
				end else begin
					if (s.mode == M_HEX0) begin
						r = push(r, tok_of(s, K_BAD, E_HEX, S_NONE));
						r.st.mode = M_IDLE;
					end else r.st.mode = M_SUFI;
					r.done = 1'b0;
				end
			end
			M_BIN0, M_BIN: begin
				if (c == CH_0 || c == CH_1) begin
					r.st = take(s, c);
					r.st.mode = M_BIN;
				end else begin
					if (s.mode == M_BIN0 || is_dig(c)) begin
						r = push(r, tok_of(s, K_BAD, E_BIN, S_NONE));
						r.st.mode = M_IDLE;
					end else r.st.mode = M_SUFI;
					r.done = 1'b0;
				end
			end
			M_OCT0, M_OCT: begin
				if (c >= CH_0 && c <= CH_7) begin
					r.st = take(s, c);
					r.st.mode = M_OCT;
				end else begin
					if (s.mode == M_OCT0 || is_dig(c)) begin
						r = push(r, tok_of(s, K_BAD, E_OCT, S_NONE));
						r.st.mode = M_IDLE;
					end else r.st.mode = M_SUFI;
					r.done = 1'b0;
				end
			end
			M_IDENT: begin
				if (id_start(c) || is_dig(c)) begin
					if (s.cnt < LEN_BITS'(KW_BYTES)) begin
						r.kw_we = 1'b1;
						r.kw_idx = s.cnt[KW_IDX_BITS-1:0];
						r.kw_d = c;
					end
					r.st = take(s, c);
				end else begin
					r = push(r, tok_of(s, ident_kind(s.cnt, kb), E_NONE, S_NONE));
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end
			end
			M_PLUS, M_MINUS, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_PIPE: begin
				pk = pair_kinds(s.mode, c);
				if (pk[13:7] != K_EOF) begin
					ns = take(s, c);
					r = push(r, tok_of(ns, pk[13:7], E_NONE, S_NONE));
					ns.mode = M_IDLE;
					r.st = ns;
				end else begin
					r = push(r, tok_of(s, pk[6:0], E_NONE, S_NONE));
					r.st.mode = M_IDLE;
					r.done = 1'b0;
				end
			end
			default: begin
				r.st.mode = M_IDLE;
				r.done = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

// File: design/sbt_front.sv
// Front end: accepts source bytes, runs the scanner state and packs the
// tokens one byte closes into a bundle. Depends on sbt_pkg.
module sbt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_end,
	input  sbt_pkg::q_stat_t q_stat,
	output logic             q_push,
	output sbt_pkg::bundle_t q_data
);
	import sbt_pkg::*;

	st_t                      st_q;
	kwbuf_t                   kb_q;
	logic                     ph2_q;
	logic [2:0]               first_q;

	logic [7:0]               c;
	st_t                      cur;
	st_t                      nst;
	it_t                      it;
	logic                     done;
	logic                     ended;
	logic [2:0]               n;
	logic [2:0]               cap;
	tok_t [MAX_RES-1:0]       toks;
	logic                     kw_we;
	logic [KW_IDX_BITS-1:0]   kw_idx;
	logic [7:0]               kw_d;
	logic                     fire;
	logic                     go_ph2;

	always_comb begin
		c = ph2_q ? CH_NUL : in_byte;
		cap = ph2_q ? (3'(MAX_RES) - first_q) : 3'(MAX_RES);
		cur = st_q;
		it = '0;
		done = 1'b0;
		ended = 1'b0;
		n = '0;
		toks = '0;
		kw_we = 1'b0;
		kw_idx = '0;
		kw_d = '0;
		for (int i = 0; i < ITERS; i++) begin
			if (!done) begin
				it = scan_iter(cur, c, kb_q);
				cur = it.st;
				done = it.done;
				ended = ended | it.ended;
				for (int j = 0; j < 2; j++) begin
					if (2'(j) < it.n && n < cap) begin
						toks[n[1:0]] = it.tok[j];
						n = n + 3'd1;
					end
				end
				if (it.done) begin
					kw_we = it.kw_we;
					kw_idx = it.kw_idx;
					kw_d = it.kw_d;
				end
			end
		end
		nst = ended ? start_state() : cur;
	end

	assign in_ready = !ph2_q && !q_stat.full;
	assign fire = ph2_q ? !q_stat.full : (in_valid && !q_stat.full);
	assign go_ph2 = !ph2_q && in_end && !ended;
	assign q_push = fire && (n != 3'd0);

	always_comb begin
		q_data.cnt = n;
		q_data.last = !go_ph2;
		q_data.tok = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= start_state();
			ph2_q <= 1'b0;
			first_q <= '0;
		end else if (fire) begin
			st_q <= nst;
			ph2_q <= go_ph2;
			first_q <= n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && kw_we) kb_q[kw_idx] <= kw_d;
	end

endmodule

// File: design/sbt_queue.sv
// Two-entry bundle queue between front and back end.
// Depends on sbt_pkg.
module sbt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sbt_pkg::bundle_t push_data,
	input  logic             pop,
	output sbt_pkg::bundle_t head,
	output sbt_pkg::q_stat_t stat
);
	import sbt_pkg::*;

	bundle_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head = mem_q[rp_q];
	assign stat.full = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

// File: design/sbt_back.sv
// Back end: walks the head bundle into the output register one token a cycle
// while the queue is not empty and the output register is empty or taken. Depends on sbt_pkg.
module sbt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sbt_pkg::bundle_t head,
	input  sbt_pkg::q_stat_t q_stat,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output sbt_pkg::tok_t    out_tok,
	output logic             out_last
);
	import sbt_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	tok_t       tok_q;
	logic       last_q;
	logic       slot;
	logic       load;
	logic       at_end;

	assign slot = !valid_q || out_ready;
	assign load = slot && !q_stat.empty;
	assign at_end = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign q_pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (slot) valid_q <= !q_stat.empty;
			if (load) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= head.tok[idx_q];
			last_q <= head.last && at_end;
		end
	end

	assign out_valid = valid_q;
	assign out_tok = tok_q;
	assign out_last = last_q;

endmodule

// File: design/source_byte_tokenizer_unit.sv
// Top level of the source byte tokenizer: front end, bundle queue, back end.
// Depends on sbt_pkg, sbt_front, sbt_queue, sbt_back and the defines header.
`include "source_byte_tokenizer_unit_defines.svh"

// One source byte is taken per clock while the two-entry bundle queue has
// room; the scanner settles each byte combinationally. A byte flagged as
// end of input (not NUL) is followed by a closing phase that takes no byte
// and ends the source with EOF. Tokens leave one per clock from the output
// register while m_tready is high; new bytes are taken while earlier tokens
// drain, as long as the queue has room. Positions and length saturate;
// after EOF the next byte starts a new source at line 1, column 1.
module source_byte_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [2:0] error_code, [5:3] literal suffix code,
	                               // [25:6] token line, [41:26] token column,
	                               // [57:42] token_length, [63:58] zero
	output logic [6:0]  m_tuser,   // [6:0] token_kind
	output logic        m_tlast    // last_result
);
	import sbt_pkg::*;

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	bundle_t q_in;
	bundle_t q_head;
	tok_t    tok;

	sbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_end   (s_tlast),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	sbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	sbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (tok),
		.out_last  (m_tlast)
	);

	assign m_tdata = {6'd0, tok.len, tok.col, tok.line, tok.suf, tok.err};
	assign m_tuser = tok.kind;

	`SBT_ASSERT_IMP(a_no_overflow, clk, arst_n, q_push, !q_stat.full)
	`SBT_ASSERT_IMP(a_no_underflow, clk, arst_n, q_pop, !q_stat.empty)
	`SBT_ASSERT_IMP(a_eof_last, clk, arst_n, m_tvalid && (m_tuser == K_EOF), m_tlast)
	`SBT_ASSERT_NEXT(a_end_stall, clk, arst_n, s_tvalid && s_tready && s_tlast && (s_tdata != CH_NUL), !s_tready)

endmodule
